// ===== hw/rtl/gdad_pkg.sv =====
`timescale 1ns / 1ps
package gdad_pkg;

    // Fixed field widths of the request and result items.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int OFFSET_W = 18;
    localparam int REM_W    = 7;   // year modulo 100
    localparam int CENT_W   = 6;   // year divided by 100
    localparam int SPAN_W   = 9;   // days in twelve consecutive months
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // Reciprocal of 100 scaled by 2^17; exact for all 12-bit years.
    localparam int RECIP_100   = 1311;
    localparam int RECIP_SHIFT = 17;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_YEAR  = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        WK_IDLE,
        WK_RUN,
        WK_DONE
    } walk_state_t;

    // Classified request handed from the front end to the walker.
    typedef struct packed {
        status_t             st;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [REM_W-1:0]    rem;
        logic [CENT_W-1:0]   cent;
    } item_info_t;

    localparam int INFO_W = $bits(item_info_t);

    // Gregorian leap rule from the year's low bits, its remainder modulo
    // 100 and its century number.
    function automatic logic leap_year(input logic [1:0] y_low,
                                       input logic [REM_W-1:0] rem,
                                       input logic [CENT_W-1:0] cent);
        leap_year = (y_low == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        case (m)
            4'd2:                month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            default:             month_len = 5'd31;
        endcase
    endfunction

endpackage

// ===== hw/rtl/gdad_fifo.sv =====
`timescale 1ns / 1ps
module gdad_fifo #(
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);
    import gdad_pkg::*;

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/gdad_front.sv =====
`timescale 1ns / 1ps
module gdad_front #(
    parameter int MIN_YEAR    = 1901,
    parameter int MAX_YEAR    = 2199,
    parameter int OFFSET_BITS = 18,
    parameter int D_W         = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gdad_pkg::DAY_W-1:0]    in_day,
    input  logic [gdad_pkg::MONTH_W-1:0]  in_month,
    input  logic [gdad_pkg::YEAR_W-1:0]   in_year,
    input  logic [gdad_pkg::OFFSET_W-1:0] offset_days,
    output logic                          push,
    input  logic                          full,
    output logic signed [D_W-1:0]         day_sum,
    output gdad_pkg::item_info_t          info
);
    import gdad_pkg::*;

    // Offset bits taken from the field; above the field width the value is
    // zero extended, so one extra bit keeps it positive.
    localparam int OB = (OFFSET_BITS > OFFSET_W) ? OFFSET_W + 1 : OFFSET_BITS;
    localparam int PROD_W = YEAR_W + 11;
    localparam logic [YEAR_W:0] MIN_Y = (YEAR_W + 1)'(MIN_YEAR);
    localparam logic [YEAR_W:0] MAX_Y = (YEAR_W + 1)'(MAX_YEAR);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DAY_W-1:0]      day_reg;
    logic [MONTH_W-1:0]    month_reg;
    logic [YEAR_W-1:0]     year_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    logic [PROD_W-1:0]     prod;
    logic [CENT_W-1:0]     cent;
    logic [YEAR_W:0]       hund;
    logic [REM_W-1:0]      rem;
    logic                  leap;
    logic [DAY_W-1:0]      len;
    logic [OFFSET_W:0]     off_ext;
    logic [OB-1:0]         off_low;
    logic signed [D_W-1:0] off_s;
    status_t               st;

    assign s_tready = !valid_reg || push;
    assign push     = valid_reg && !full;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Request holding register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            day_reg    <= in_day;
            month_reg  <= in_month;
            year_reg   <= in_year;
            offset_reg <= offset_days;
        end
    end

    // Split the year into century and remainder by a reciprocal multiply.
    always_comb begin
        prod = PROD_W'(year_reg) * PROD_W'(RECIP_100);
        cent = prod[RECIP_SHIFT +: CENT_W];
        hund = (YEAR_W + 1)'(cent) * (YEAR_W + 1)'(100);
        rem  = REM_W'({1'b0, year_reg} - hund);
        leap = leap_year(year_reg[1:0], rem, cent);
        len  = month_len(month_reg, leap);
    end

    // Classify the start date; year first, then month, then day.
    always_comb begin
        if (({1'b0, year_reg} < MIN_Y) || ({1'b0, year_reg} > MAX_Y)) begin
            st = ST_BAD_YEAR;
        end else if (!(month_reg inside {[4'd1:4'd12]})) begin
            st = ST_BAD_MONTH;
        end else if ((day_reg == '0) || (day_reg > len)) begin
            st = ST_BAD_DAY;
        end else begin
            st = ST_OK;
        end
    end

    // Sign extend the offset and add the start day.
    always_comb begin
        off_ext = {1'b0, offset_reg};
        off_low = off_ext[OB-1:0];
        off_s   = {{(D_W - OB){off_low[OB-1]}}, off_low};
        day_sum = off_s + $signed(D_W'(day_reg));
    end

    always_comb begin
        info.st    = st;
        info.month = month_reg;
        info.year  = year_reg;
        info.rem   = rem;
        info.cent  = cent;
    end

endmodule

// ===== hw/rtl/gdad_walk.sv =====
`timescale 1ns / 1ps
module gdad_walk #(
    parameter int MIN_YEAR = 1901,
    parameter int MAX_YEAR = 2199,
    parameter int D_W      = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fifo_valid,
    output logic                         fifo_pop,
    input  logic signed [D_W-1:0]        day_sum,
    input  gdad_pkg::item_info_t         info,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gdad_pkg::DAY_W-1:0]   out_day,
    output logic [gdad_pkg::MONTH_W-1:0] out_month,
    output logic [gdad_pkg::YEAR_W-1:0]  out_year,
    output logic [2:0]                   status
);
    import gdad_pkg::*;

    localparam logic [YEAR_W:0] MIN_Y = (YEAR_W + 1)'(MIN_YEAR);
    localparam logic [YEAR_W:0] MAX_Y = (YEAR_W + 1)'(MAX_YEAR);
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(99);
    localparam logic [SPAN_W-1:0] YEAR_DAYS = SPAN_W'(365);

    walk_state_t           state_reg;
    walk_state_t           state_next;
    logic signed [D_W-1:0] d_reg;
    logic signed [D_W-1:0] d_next;
    logic [MONTH_W-1:0]    m_reg;
    logic [MONTH_W-1:0]    m_next;
    logic [YEAR_W-1:0]     y_reg;
    logic [YEAR_W-1:0]     y_next;
    logic [REM_W-1:0]      r_reg;
    logic [REM_W-1:0]      r_next;
    logic [CENT_W-1:0]     q_reg;
    logic [CENT_W-1:0]     q_next;
    status_t               st_reg;
    status_t               st_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DAY_W-1:0]      out_day_reg;
    logic [MONTH_W-1:0]    out_month_reg;
    logic [YEAR_W-1:0]     out_year_reg;
    logic [2:0]            out_st_reg;
    logic                  out_free;
    logic                  out_load;

    logic [YEAR_W:0]       y_up;
    logic [YEAR_W:0]       y_dn;
    logic                  ok_up;
    logic                  ok_dn;
    logic [REM_W-1:0]      r_up;
    logic [REM_W-1:0]      r_dn;
    logic [CENT_W-1:0]     q_up;
    logic [CENT_W-1:0]     q_dn;
    logic                  leap_c;
    logic                  leap_up;
    logic                  leap_dn;
    logic [DAY_W-1:0]      len_c;
    logic [DAY_W-1:0]      len_prev;
    logic [SPAN_W-1:0]     fwd_span;
    logic [SPAN_W-1:0]     bwd_span;
    logic signed [D_W-1:0] len_s;
    logic signed [D_W-1:0] fwd_s;
    logic signed [D_W-1:0] bwd_s;
    logic                  walk_finish;

    assign out_free = !out_valid_reg || m_tready;

    // Neighbor years, their leap flags and whether they are in range.
    always_comb begin
        y_up    = {1'b0, y_reg} + (YEAR_W + 1)'(1);
        y_dn    = {1'b0, y_reg} - (YEAR_W + 1)'(1);
        ok_up   = (y_up >= MIN_Y) && (y_up <= MAX_Y);
        ok_dn   = (y_dn >= MIN_Y) && (y_dn <= MAX_Y);
        r_up    = (r_reg == REM_LAST) ? '0 : r_reg + REM_W'(1);
        q_up    = (r_reg == REM_LAST) ? q_reg + CENT_W'(1) : q_reg;
        r_dn    = (r_reg == '0) ? REM_LAST : r_reg - REM_W'(1);
        q_dn    = (r_reg == '0) ? q_reg - CENT_W'(1) : q_reg;
        leap_c  = leap_year(y_reg[1:0], r_reg, q_reg);
        leap_up = leap_year(y_up[1:0], r_up, q_up);
        leap_dn = leap_year(y_dn[1:0], r_dn, q_dn);
        len_c   = month_len(m_reg, leap_c);
        len_prev = month_len(m_reg - MONTH_W'(1), leap_c);
        // Twelve months ahead hold next February once past this one.
        fwd_span = YEAR_DAYS + SPAN_W'((m_reg <= MONTH_FEB) ? leap_c : leap_up);
        // Twelve months back hold this February once it has passed.
        bwd_span = YEAR_DAYS + SPAN_W'((m_reg > MONTH_FEB) ? leap_c : leap_dn);
        len_s   = $signed(D_W'(len_c));
        fwd_s   = $signed(D_W'(fwd_span));
        bwd_s   = $signed(D_W'(bwd_span));
    end

    // One walk step: a whole year when the remainder allows, else a month.
    always_comb begin
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        st_next     = st_reg;
        walk_finish = 1'b0;
        case (state_reg)
            WK_IDLE: begin
                if (fifo_valid) begin
                    d_next  = day_sum;
                    m_next  = info.month;
                    y_next  = info.year;
                    r_next  = info.rem;
                    q_next  = info.cent;
                    st_next = info.st;
                end
            end
            WK_RUN: begin
                if (d_reg > len_s) begin
                    if (d_reg > fwd_s) begin
                        if (!ok_up) begin
                            st_next     = ST_RANGE;
                            walk_finish = 1'b1;
                        end else begin
                            d_next = d_reg - fwd_s;
                            y_next = y_up[YEAR_W-1:0];
                            r_next = r_up;
                            q_next = q_up;
                        end
                    end else if (m_reg == MONTH_DEC) begin
                        if (!ok_up) begin
                            st_next     = ST_RANGE;
                            walk_finish = 1'b1;
                        end else begin
                            d_next = d_reg - len_s;
                            y_next = y_up[YEAR_W-1:0];
                            r_next = r_up;
                            q_next = q_up;
                            m_next = MONTH_JAN;
                        end
                    end else begin
                        d_next = d_reg - len_s;
                        m_next = m_reg + MONTH_W'(1);
                    end
                end else if (d_reg < $signed(D_W'(1))) begin
                    if ((d_reg + bwd_s) < $signed(D_W'(1))) begin
                        if (!ok_dn) begin
                            st_next     = ST_RANGE;
                            walk_finish = 1'b1;
                        end else begin
                            d_next = d_reg + bwd_s;
                            y_next = y_dn[YEAR_W-1:0];
                            r_next = r_dn;
                            q_next = q_dn;
                        end
                    end else if (m_reg == MONTH_JAN) begin
                        if (!ok_dn) begin
                            st_next     = ST_RANGE;
                            walk_finish = 1'b1;
                        end else begin
                            // December always has 31 days.
                            d_next = d_reg + $signed(D_W'(31));
                            y_next = y_dn[YEAR_W-1:0];
                            r_next = r_dn;
                            q_next = q_dn;
                            m_next = MONTH_DEC;
                        end
                    end else begin
                        d_next = d_reg + $signed(D_W'(len_prev));
                        m_next = m_reg - MONTH_W'(1);
                    end
                end else begin
                    walk_finish = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            WK_IDLE: begin
                if (fifo_valid) begin
                    state_next = (info.st == ST_OK) ? WK_RUN : WK_DONE;
                end
            end
            WK_RUN: begin
                if (walk_finish) begin
                    state_next = WK_DONE;
                end
            end
            WK_DONE: begin
                if (out_free) begin
                    state_next = WK_IDLE;
                end
            end
            default: begin
                state_next = WK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        fifo_pop = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            WK_IDLE: fifo_pop = fifo_valid;
            WK_DONE: out_load = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= WK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk datapath and result register.
    always_ff @(posedge aclk) begin
        d_reg  <= d_next;
        m_reg  <= m_next;
        y_reg  <= y_next;
        r_reg  <= r_next;
        q_reg  <= q_next;
        st_reg <= st_next;
        if (out_load) begin
            out_day_reg   <= (st_reg == ST_OK) ? d_reg[DAY_W-1:0] : '0;
            out_month_reg <= (st_reg == ST_OK) ? m_reg : '0;
            out_year_reg  <= (st_reg == ST_OK) ? y_reg : '0;
            out_st_reg    <= st_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_day   = out_day_reg;
    assign out_month = out_month_reg;
    assign out_year  = out_year_reg;
    assign status    = out_st_reg;

endmodule

// ===== hw/rtl/gregorian_date_add_days_core.sv =====
`timescale 1ns / 1ps
// Flow: the front-end register and the queue hold each request, then the walker
// takes one walk step per cycle (a whole year while at least twelve months remain,
// else a month) and the result register presents the result once the output is free.
// The walker holds one item at a time; the front end and queue take requests until full.
// Reset: synchronous active-low aresetn empties the front end, queue and
// result register; no stored data needs clearing.
module gregorian_date_add_days_core #(
    parameter int MIN_YEAR    = 1901,
    parameter int MAX_YEAR    = 2199,
    parameter int OFFSET_BITS = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_day, in_month, in_year, offset_days, zero pad
    input  logic [gdad_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_day, out_month, out_year, status
    output logic [gdad_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import gdad_pkg::*;

    localparam int OB  = (OFFSET_BITS > OFFSET_W) ? OFFSET_W + 1 : OFFSET_BITS;
    localparam int D_W = OB + 2;
    localparam int Q_W = D_W + INFO_W;

    logic                  push;
    logic                  full;
    logic                  pop;
    logic                  not_empty;
    logic signed [D_W-1:0] f_day_sum;
    item_info_t            f_info;
    logic [Q_W-1:0]        q_out;
    logic signed [D_W-1:0] w_day_sum;
    item_info_t            w_info;
    logic [DAY_W-1:0]      out_day;
    logic [MONTH_W-1:0]    out_month;
    logic [YEAR_W-1:0]     out_year;
    logic [2:0]            status;

    gdad_front #(
        .MIN_YEAR    (MIN_YEAR),
        .MAX_YEAR    (MAX_YEAR),
        .OFFSET_BITS (OFFSET_BITS),
        .D_W         (D_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_day      (s_tdata[4:0]),
        .in_month    (s_tdata[8:5]),
        .in_year     (s_tdata[20:9]),
        .offset_days (s_tdata[38:21]),
        .push        (push),
        .full        (full),
        .day_sum     (f_day_sum),
        .info        (f_info)
    );

    gdad_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({f_day_sum, f_info}),
        .full      (full),
        .pop       (pop),
        .pop_data  (q_out),
        .not_empty (not_empty)
    );

    assign w_day_sum = q_out[Q_W-1 -: D_W];
    assign w_info    = item_info_t'(q_out[INFO_W-1:0]);

    gdad_walk #(
        .MIN_YEAR (MIN_YEAR),
        .MAX_YEAR (MAX_YEAR),
        .D_W      (D_W)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_valid (not_empty),
        .fifo_pop   (pop),
        .day_sum    (w_day_sum),
        .info       (w_info),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_day    (out_day),
        .out_month  (out_month),
        .out_year   (out_year),
        .status     (status)
    );

    assign m_tdata = {status, out_year, out_month, out_day};

`ifndef NO_ASSERTIONS
    // The queue never takes a request while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue overflow");

    // Any error status clears the date fields.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status != 3'(ST_OK))) |-> (m_tdata[20:0] == 21'd0))
        else $error("error result carries a date");

    // A good result is a real calendar position.
    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status == 3'(ST_OK))) |->
            ((out_day != '0) && (out_month != '0) && (out_month <= MONTH_DEC)))
        else $error("bad result date");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status <= 3'(ST_RANGE)))
        else $error("undefined status code");
`endif

endmodule

// ===== dv/tb_gregorian_date_add_days_core.sv =====
`timescale 1ns / 1ps
module tb_gregorian_date_add_days_core;
    import gdad_pkg::*;

    localparam int MIN_YEAR    = 1901;
    localparam int MAX_YEAR    = 2199;
    localparam int OFFSET_BITS = 18;
    localparam int RANDOM_REQUESTS = 550;
    localparam int DRAIN_CYCLES    = 400;
    localparam int CYCLE_LIMIT     = 1000000;

    // One date request as the block sees it.
    typedef struct {
        logic [DAY_W-1:0]           day;
        logic [MONTH_W-1:0]         month;
        logic [YEAR_W-1:0]          year;
        logic signed [OFFSET_W-1:0] offset;
    } date_req_t;

    // One resulting date with its status.
    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        status_t            st;
    } date_result_t;

    // Predicts each accepted request and compares the block's results in order.
    class date_scoreboard;
        date_result_t due_dates[$];
        int errors;
        int checked;
        int status_seen[5];

        function bit is_leap(int y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int days_in_month(int m, int y);
            if (m == MONTH_FEB)
                return is_leap(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function bit year_in_range(int y);
            return y >= MIN_YEAR && y <= MAX_YEAR;
        endfunction

        // Validate the start date, then walk month by month.
        function date_result_t predict_date(date_req_t r);
            date_result_t res;
            int d;
            int m;
            int y;
            status_t st;
            d = r.day;
            m = r.month;
            y = r.year;
            st = ST_OK;
            if (!year_in_range(y))
                st = ST_BAD_YEAR;
            else if (m < 1 || m > 12)
                st = ST_BAD_MONTH;
            else if (d < 1 || d > days_in_month(m, y))
                st = ST_BAD_DAY;

            if (st == ST_OK) begin
                d = d + int'(r.offset);
                while (st == ST_OK && d > days_in_month(m, y)) begin
                    d = d - days_in_month(m, y);
                    if (m == MONTH_DEC) begin
                        if (!year_in_range(y + 1)) begin
                            st = ST_RANGE;
                        end else begin
                            y = y + 1;
                            m = MONTH_JAN;
                        end
                    end else begin
                        m = m + 1;
                    end
                end
                while (st == ST_OK && d < 1) begin
                    if (m == MONTH_JAN) begin
                        if (!year_in_range(y - 1)) begin
                            st = ST_RANGE;
                        end else begin
                            y = y - 1;
                            m = MONTH_DEC;
                        end
                    end else begin
                        m = m - 1;
                    end
                    if (st == ST_OK)
                        d = d + days_in_month(m, y);
                end
            end

            res.st = st;
            if (st != ST_OK) begin
                res.day   = '0;
                res.month = '0;
                res.year  = '0;
            end else begin
                res.day   = d[DAY_W-1:0];
                res.month = m[MONTH_W-1:0];
                res.year  = y[YEAR_W-1:0];
            end
            return res;
        endfunction

        function void note_request(date_req_t r);
            due_dates.push_back(predict_date(r));
        endfunction

        function int pending();
            return due_dates.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            date_result_t exp;
            logic [DAY_W-1:0]   got_day;
            logic [MONTH_W-1:0] got_month;
            logic [YEAR_W-1:0]  got_year;
            logic [2:0]         got_st;
            got_day   = data[DAY_W-1:0];
            got_month = data[DAY_W+MONTH_W-1:DAY_W];
            got_year  = data[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W];
            got_st    = data[OUT_TDATA_W-1:DAY_W+MONTH_W+YEAR_W];
            if (due_dates.size() == 0) begin
                report($sformatf("result %h arrived with no request pending", data));
            end else begin
                exp = due_dates.pop_front();
                checked++;
                status_seen[int'(exp.st)]++;
                if (got_day !== exp.day)
                    report($sformatf("day got %0d want %0d", got_day, exp.day));
                if (got_month !== exp.month)
                    report($sformatf("month got %0d want %0d", got_month, exp.month));
                if (got_year !== exp.year)
                    report($sformatf("year got %0d want %0d", got_year, exp.year));
                if (got_st !== exp.st)
                    report($sformatf("status got %0d want %0d", got_st, exp.st));
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // in_day, in_month, in_year, offset_days, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // out_day, out_month, out_year, status
    logic [OUT_TDATA_W-1:0] m_tdata;

    date_scoreboard sb = new();
    int cycle_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;

    gregorian_date_add_days_core #(
        .MIN_YEAR(MIN_YEAR),
        .MAX_YEAR(MAX_YEAR),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check every result taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver backpressure: modes of always ready, random ready and long stalls.
    int rx_mode = 0;
    int rx_left = 0;
    int rx_hold = 0;
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold = $urandom_range(1, 24);
                end
            end
        endcase
    end

    function automatic date_req_t make_req(int d, int m, int y, int off);
        date_req_t r;
        r.day    = d[DAY_W-1:0];
        r.month  = m[MONTH_W-1:0];
        r.year   = y[YEAR_W-1:0];
        r.offset = off[OFFSET_W-1:0];
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(date_req_t r);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.offset, r.year, r.month, r.day};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        sent_count++;
    endtask

    // Sender bursts: after each burst, drop valid for a random gap, or carry straight on.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic send_paced(date_req_t r);
        send_request(r);
        pace_sender();
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Mostly well-formed dates with offsets of mixed size; the rest is edges and noise.
    function automatic date_req_t random_request();
        date_req_t r;
        int pick;
        int kind;
        int len;
        int mag;
        int y;
        int m;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 9);
        y = $urandom_range(MIN_YEAR, MAX_YEAR);
        m = $urandom_range(1, 12);
        if (pick >= 80 && pick < 90)
            y = $urandom_range(0, 1) ? $urandom_range(1898, 1904) : $urandom_range(2196, 2202);
        len = sb.days_in_month(m, y);
        r.year  = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = DAY_W'($urandom_range(1, len));

        if (kind < 4)
            mag = $urandom_range(0, 60);
        else if (kind < 7)
            mag = $urandom_range(0, 1000);
        else if (kind < 9)
            mag = $urandom_range(0, 40000);
        else
            mag = $urandom_range(0, 131072);
        r.offset = OFFSET_W'($urandom_range(0, 1) ? -mag : mag);

        if (pick >= 70 && pick < 80) begin
            // Day zero, or right at or past the end of the month.
            case ($urandom_range(0, 3))
                0: r.day = '0;
                1: r.day = DAY_W'(len);
                2: r.day = DAY_W'(len + 1);
                default: r.day = 5'd31;
            endcase
        end else if (pick >= 90) begin
            r.day    = DAY_W'($urandom);
            r.month  = MONTH_W'($urandom);
            r.year   = YEAR_W'($urandom);
            r.offset = OFFSET_W'($urandom);
        end
        return r;
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests: range edges, leap rule, bad fields and check order.
        send_paced(make_req(1, 1, 1901, 0));
        send_paced(make_req(31, 12, 2199, 0));
        send_paced(make_req(31, 12, 2199, 1));
        send_paced(make_req(1, 1, 1901, -1));
        send_paced(make_req(1, 1, 1901, 109207));
        send_paced(make_req(31, 12, 2199, -109207));
        send_paced(make_req(1, 1, 1901, 131071));
        send_paced(make_req(31, 12, 2199, -131072));
        send_paced(make_req(1, 7, 2050, -131072));
        send_paced(make_req(29, 2, 2000, 365));
        send_paced(make_req(29, 2, 2100, 0));
        send_paced(make_req(29, 2, 2096, 1));
        send_paced(make_req(30, 2, 2000, 0));
        send_paced(make_req(1, 3, 2000, -1));
        send_paced(make_req(31, 1, 2000, 29));
        send_paced(make_req(1, 3, 2100, -1));
        send_paced(make_req(0, 5, 2000, 0));
        send_paced(make_req(31, 4, 2000, 0));
        send_paced(make_req(1, 0, 2000, 0));
        send_paced(make_req(1, 13, 2000, 0));
        send_paced(make_req(31, 15, 4095, -1));
        send_paced(make_req(1, 1, 1900, 0));
        send_paced(make_req(1, 1, 2200, 0));
        send_paced(make_req(0, 0, 0, 0));
        send_paced(make_req(0, 13, 2200, 5));

        // Hold the sender until the block has delivered everything.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            send_paced(random_request());
            if (i == RANDOM_REQUESTS / 2) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d date requests, checked %0d results in %0d cycles",
                 sent_count, sb.checked, cycle_count);
        $display("outcomes: ok %0d, bad year %0d, bad month %0d, bad day %0d, out of range %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
